### rtl/xsfu_pkg.sv
// Shared types, codes and helper functions for the x86 status flag unit.
package xsfu_pkg;

   // Request kinds
   localparam logic [2:0] KIND_ADD   = 3'd0;
   localparam logic [2:0] KIND_SUB   = 3'd1;
   localparam logic [2:0] KIND_COND  = 3'd2;
   localparam logic [2:0] KIND_READ  = 3'd3;
   localparam logic [2:0] KIND_WRITE = 3'd4;

   // Operand width codes
   localparam logic [1:0] WID_8  = 2'd0;
   localparam logic [1:0] WID_16 = 2'd1;
   localparam logic [1:0] WID_32 = 2'd2;
   localparam logic [1:0] WID_64 = 2'd3;

   // Condition selectors (cond[3:1])
   localparam logic [2:0] CSEL_O  = 3'd0;
   localparam logic [2:0] CSEL_C  = 3'd1;
   localparam logic [2:0] CSEL_Z  = 3'd2;
   localparam logic [2:0] CSEL_BE = 3'd3;
   localparam logic [2:0] CSEL_S  = 3'd4;
   localparam logic [2:0] CSEL_P  = 3'd5;
   localparam logic [2:0] CSEL_L  = 3'd6;
   localparam logic [2:0] CSEL_LE = 3'd7;

   // Bit index of each flag in the internal flag vector
   localparam int FL_CF = 0;
   localparam int FL_PF = 1;
   localparam int FL_AF = 2;
   localparam int FL_ZF = 3;
   localparam int FL_SF = 4;
   localparam int FL_DF = 5;
   localparam int FL_OF = 6;
   localparam int NUM_FLAGS = 7;

   // Position of each flag in the architectural flag word
   localparam int POS_CF = 0;
   localparam int POS_PF = 2;
   localparam int POS_AF = 4;
   localparam int POS_ZF = 6;
   localparam int POS_SF = 7;
   localparam int POS_DF = 10;
   localparam int POS_OF = 11;

   // Fixed bits of the flag word (reserved bit 1 and IF)
   localparam logic [63:0] FLAG_WORD_BASE = 64'h202;

   // AF comes from the carry out of the low nibble
   localparam int AF_BIT = 4;

   typedef logic [NUM_FLAGS-1:0] flags_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [1:0]  width_code;
      logic [63:0] lhs;
      logic [63:0] rhs;
      logic [63:0] res;
      logic        keep_carry;
      logic [3:0]  cond;
      logic [63:0] word_in;
   } req_type;

   typedef struct packed {
      logic        cond_true;
      logic [63:0] flag_word;
      flags_type   flags_now;
   } rsp_type;

   // Low-bits mask for an operand width
   function automatic logic [63:0] width_mask(input logic [1:0] wc);
      logic [63:0] m;
      case (wc)
         WID_8:   m = 64'h0000_0000_0000_00FF;
         WID_16:  m = 64'h0000_0000_0000_FFFF;
         WID_32:  m = 64'h0000_0000_FFFF_FFFF;
         default: m = 64'hFFFF_FFFF_FFFF_FFFF;
      endcase
      return m;
   endfunction

   // Sign bit of a value at an operand width
   function automatic logic sign_at(input logic [63:0] v, input logic [1:0] wc);
      logic s;
      case (wc)
         WID_8:   s = v[7];
         WID_16:  s = v[15];
         WID_32:  s = v[31];
         default: s = v[63];
      endcase
      return s;
   endfunction

   // Even parity of the low byte
   function automatic logic even_parity8(input logic [63:0] v);
      return ~(^v[7:0]);
   endfunction

endpackage

### rtl/x86_status_flag_unit.sv
// Top level of the x86 status flag unit.
//
//   channel | direction | handshake            | payload
//   req_    | in        | req_valid/req_ready  | kind, width_code, lhs, rhs, res,
//           |           |                      | keep_carry, cond, word_in
//   rsp_    | out       | rsp_valid/rsp_ready  | cond_true, flag_word, flags_now
//
// One word per cycle sustained while rsp_ready stays high; a word passes through the input
// register, then the flag logic into the result register, before rsp_valid shows it.
// The flag register updates as a word moves into the result register, so each
// word sees the flags left by all words before it.
// Synchronous reset clears both valid bits and all flags.
// A stalled rsp_ tolerates one more word held in the input register; req_ready
// drops only when both registers are full and rsp_ready is low.
module x86_status_flag_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_kind,
   input  logic [1:0]  req_width_code,
   input  logic [63:0] req_lhs,
   input  logic [63:0] req_rhs,
   input  logic [63:0] req_res,
   input  logic        req_keep_carry,
   input  logic [3:0]  req_cond,
   input  logic [63:0] req_word_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_cond_true,
   output logic [63:0] rsp_flag_word,
   output logic [6:0]  rsp_flags_now
);
   import xsfu_pkg::*;

   req_type in_word, stage_word;
   rsp_type next_rsp, out_word;
   logic    stage_valid, out_valid, advance;

   assign in_word.kind       = req_kind;
   assign in_word.width_code = req_width_code;
   assign in_word.lhs        = req_lhs;
   assign in_word.rhs        = req_rhs;
   assign in_word.res        = req_res;
   assign in_word.keep_carry = req_keep_carry;
   assign in_word.cond       = req_cond;
   assign in_word.word_in    = req_word_in;

   // Move a word forward when the result register is free or being emptied
   assign advance = stage_valid && (!out_valid || rsp_ready);

   xsfu_in_stage u_in (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .in_word     (in_word),
      .advance     (advance),
      .stage_valid (stage_valid),
      .stage_word  (stage_word)
   );

   xsfu_exec u_exec (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .req     (stage_word),
      .rsp     (next_rsp)
   );

   xsfu_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .next_word (next_rsp),
      .out_valid (out_valid),
      .out_ready (rsp_ready),
      .out_word  (out_word)
   );

   assign rsp_valid     = out_valid;
   assign rsp_cond_true = out_word.cond_true;
   assign rsp_flag_word = out_word.flag_word;
   assign rsp_flags_now = out_word.flags_now;

endmodule

### rtl/xsfu_in_stage.sv
// Input register stage: captures one request word per cycle while the stage is free or its word moves on.
module xsfu_in_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  xsfu_pkg::req_type in_word,
   input  logic             advance,
   output logic             stage_valid,
   output xsfu_pkg::req_type stage_word
);
   import xsfu_pkg::*;

   logic    valid_ff, valid_in;
   req_type word_ff, word_in;
   logic    load;

   // Stage frees up in the same cycle its word moves on
   assign in_ready = !valid_ff || advance;
   assign load     = in_valid && in_ready;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (load) begin
         valid_in = 1'b1;
         word_in  = in_word;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign stage_valid = valid_ff;
   assign stage_word  = word_ff;

endmodule

### rtl/xsfu_exec.sv
// Flag state register and the single-pass flag / condition / flag word logic.
module xsfu_exec (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  xsfu_pkg::req_type  req,
   output xsfu_pkg::rsp_type  rsp
);
   import xsfu_pkg::*;

   flags_type flags_ff, flags_in;

   always_comb begin
      logic [63:0] m;
      logic [63:0] lhs, rhs, res;
      logic        sl, sr, sres;
      logic        slt;
      logic        cr;
      logic [63:0] word;
      logic        wide;

      m    = width_mask(req.width_code);
      lhs  = req.lhs & m;
      rhs  = req.rhs & m;
      res  = req.res & m;
      sl   = sign_at(lhs, req.width_code);
      sr   = sign_at(rhs, req.width_code);
      sres = sign_at(res, req.width_code);
      // signed less-than at width: differing signs decide, else unsigned compare
      slt  = (sl != sr) ? sl : (lhs < rhs);

      cr   = 1'b0;
      word = '0;
      wide = 1'b0;

      flags_in      = flags_ff;
      rsp.cond_true = 1'b0;
      rsp.flag_word = '0;

      case (req.kind)
         KIND_ADD: begin
            flags_in[FL_SF] = sres;
            flags_in[FL_PF] = even_parity8(res);
            flags_in[FL_AF] = lhs[AF_BIT] ^ rhs[AF_BIT] ^ res[AF_BIT];
            flags_in[FL_ZF] = (res == '0);
            if (!req.keep_carry) begin
               flags_in[FL_CF] = (res < lhs);
            end
            flags_in[FL_OF] = (sl == sr) && (sres != sl);
         end
         KIND_SUB: begin
            flags_in[FL_SF] = sres;
            flags_in[FL_PF] = even_parity8(res);
            flags_in[FL_AF] = lhs[AF_BIT] ^ rhs[AF_BIT] ^ res[AF_BIT];
            flags_in[FL_ZF] = (lhs == rhs);
            if (!req.keep_carry) begin
               flags_in[FL_CF] = (lhs < rhs);
            end
            flags_in[FL_OF] = sres ^ slt;
         end
         KIND_COND: begin
            case (req.cond[3:1])
               CSEL_O:  cr = flags_ff[FL_OF];
               CSEL_C:  cr = flags_ff[FL_CF];
               CSEL_Z:  cr = flags_ff[FL_ZF];
               CSEL_BE: cr = flags_ff[FL_CF] | flags_ff[FL_ZF];
               CSEL_S:  cr = flags_ff[FL_SF];
               CSEL_P:  cr = flags_ff[FL_PF];
               CSEL_L:  cr = flags_ff[FL_SF] ^ flags_ff[FL_OF];
               default: cr = flags_ff[FL_ZF] | (flags_ff[FL_SF] ^ flags_ff[FL_OF]);
            endcase
            rsp.cond_true = cr ^ req.cond[0];
         end
         KIND_READ: begin
            word         = FLAG_WORD_BASE;
            word[POS_CF] = flags_ff[FL_CF];
            word[POS_PF] = flags_ff[FL_PF];
            word[POS_AF] = flags_ff[FL_AF];
            word[POS_ZF] = flags_ff[FL_ZF];
            word[POS_SF] = flags_ff[FL_SF];
            word[POS_DF] = flags_ff[FL_DF];
            word[POS_OF] = flags_ff[FL_OF];
            rsp.flag_word = word & m;
         end
         KIND_WRITE: begin
            // DF and OF sit above bit 7, so a byte-wide write skips them
            wide = (req.width_code != WID_8);
            flags_in[FL_CF] = req.word_in[POS_CF];
            flags_in[FL_PF] = req.word_in[POS_PF];
            flags_in[FL_AF] = req.word_in[POS_AF];
            flags_in[FL_ZF] = req.word_in[POS_ZF];
            flags_in[FL_SF] = req.word_in[POS_SF];
            if (wide) begin
               flags_in[FL_DF] = req.word_in[POS_DF];
               flags_in[FL_OF] = req.word_in[POS_OF];
            end
         end
         default: begin
            flags_in = flags_ff;
         end
      endcase

      rsp.flags_now = flags_in;
   end

   // Flags commit when the word moves into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else if (advance) begin
         flags_ff <= flags_in;
      end
   end

endmodule

### rtl/xsfu_out_stage.sv
// Result register: holds one response word until the consumer takes it.
module xsfu_out_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  xsfu_pkg::rsp_type  next_word,
   output logic              out_valid,
   input  logic              out_ready,
   output xsfu_pkg::rsp_type  out_word
);
   import xsfu_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type word_ff, word_in;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (advance) begin
         valid_in = 1'b1;
         word_in  = next_word;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

### rtl/xsfu_checker.sv
// Port-level checks for the x86 status flag unit, bound to the top level.
module xsfu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_cond_true,
   input logic [63:0] rsp_flag_word,
   input logic [6:0]  rsp_flags_now
);

   // Only flag positions and the fixed bits can appear in the flag word
   localparam logic [63:0] WORD_BITS = 64'hED7;

   // Reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // A stalled response keeps its word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_flags_now)
         && $stable(rsp_flag_word) && $stable(rsp_cond_true))
      else $error("stalled response changed");

   // A condition result and a flag word never come from the same word
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_cond_true && (rsp_flag_word != 64'd0)))
      else $error("cond_true and flag_word both set");

   // A flag word read always carries the reserved bit and no stray bits
   a_word_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_flag_word != 64'd0) |->
         rsp_flag_word[1] && ((rsp_flag_word & ~WORD_BITS) == 64'd0))
      else $error("malformed flag word");

   // Nothing is returned just after reset is released unless a request was accepted
   a_no_invent: assert property (@(posedge clock)
      $past(reset) && !(req_valid && req_ready) |=> !rsp_valid)
      else $error("response without request");

endmodule

bind x86_status_flag_unit xsfu_checker u_xsfu_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_cond_true (rsp_cond_true),
   .rsp_flag_word (rsp_flag_word),
   .rsp_flags_now (rsp_flags_now)
);
